// File: rtl/tcgc_pkg.sv
// ----------------------------------------------------------------------------
// tcgc_pkg
// Shared types for the text cell glyph compositor: opcodes, configuration
// bundle and the command word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package tcgc_pkg;

  typedef enum logic [1:0] {
    OP_GLYPH = 2'd0,
    OP_FILL  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // configuration register index, register i sits at byte address 4*i
  typedef enum logic [2:0] {
    REG_CELL_W   = 3'd0,
    REG_CELL_H   = 3'd1,
    REG_ASCENDER = 3'd2,
    REG_DISP_W   = 3'd3,
    REG_DISP_H   = 3'd4
  } reg_e;

  typedef struct packed {
    logic [7:0]  cell_w;
    logic [7:0]  cell_h;
    logic [7:0]  ascender;
    logic [12:0] disp_w;
    logic [12:0] disp_h;
  } cfg_t;

  // x0/y0 hold the cell origin for a pixel, the rectangle origin for a flush
  typedef struct packed {
    op_e               op;
    logic [15:0]       x0;
    logic [14:0]       y0;
    logic [15:0]       rect_w;
    logic [14:0]       rect_h;
    logic              dirty;
    logic [7:0]        pix_x;
    logic [7:0]        pix_y;
    logic signed [7:0] glyph_left;
    logic signed [8:0] glyph_top;
    logic [7:0]        coverage;
    logic              bold;
    logic [2:0]        fg_color;
    logic [2:0]        bg_color;
  } cmd_t;

endpackage

// File: rtl/tcgc_fifo.sv
// ----------------------------------------------------------------------------
// tcgc_fifo
// Small flop-based queue between the command front end and the pixel back end.
// ----------------------------------------------------------------------------
module tcgc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign wr_ready_o = (count_q != CntW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count above depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

// File: rtl/tcgc_front.sv
// ----------------------------------------------------------------------------
// tcgc_front
// Command front end: decodes each word, tracks the dirty cell rectangle and
// forms the cell or rectangle origin and extent for the back end.
// ----------------------------------------------------------------------------
module tcgc_front #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcgc_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_tuser_i,  // opcode
  input  logic [63:0]         in_tdata_i,  // see top level for layout
  output logic                wr_valid_o,
  input  logic                wr_ready_i,
  output tcgc_pkg::cmd_t      wr_data_o
);
  import tcgc_pkg::*;

  localparam logic [7:0] ColMax = 8'(MAX_COLS - 1);
  localparam logic [6:0] RowMax = 7'(MAX_ROWS - 1);

  logic       any_q, any_d;
  logic [7:0] min_col_q, min_col_d, max_col_q, max_col_d;
  logic [6:0] min_row_q, min_row_d, max_row_q, max_row_d;

  op_e        op;
  logic [7:0] col, col_c, mul_col;
  logic [6:0] row, row_c, mul_row;
  logic [8:0] span_col;
  logic [7:0] span_row;
  logic       accept;

  assign op     = op_e'(in_tuser_i);
  assign col    = in_tdata_i[7:0];
  assign row    = in_tdata_i[14:8];
  assign col_c  = (col > ColMax) ? ColMax : col;
  assign row_c  = (row > RowMax) ? RowMax : row;
  assign accept = in_valid_i & wr_ready_i;

  assign in_ready_o = wr_ready_i;
  assign wr_valid_o = in_valid_i;

  always_comb begin
    any_d     = any_q;
    min_col_d = min_col_q;
    max_col_d = max_col_q;
    min_row_d = min_row_q;
    max_row_d = max_row_q;
    unique case (op)
      OP_GLYPH, OP_FILL: begin
        if (!any_q) begin
          any_d     = 1'b1;
          min_col_d = col_c;
          max_col_d = col_c;
          min_row_d = row_c;
          max_row_d = row_c;
        end else begin
          if (col_c < min_col_q) min_col_d = col_c;
          if (col_c > max_col_q) max_col_d = col_c;
          if (row_c < min_row_q) min_row_d = row_c;
          if (row_c > max_row_q) max_row_d = row_c;
        end
      end
      OP_FLUSH: begin
        any_d     = 1'b0;
        min_col_d = '0;
        max_col_d = '0;
        min_row_d = '0;
        max_row_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q     <= 1'b0;
      min_col_q <= '0;
      max_col_q <= '0;
      min_row_q <= '0;
      max_row_q <= '0;
    end else if (accept) begin
      any_q     <= any_d;
      min_col_q <= min_col_d;
      max_col_q <= max_col_d;
      min_row_q <= min_row_d;
      max_row_q <= max_row_d;
    end
  end

  // origin multipliers are shared between pixel placement and flush
  assign mul_col  = (op == OP_FLUSH) ? min_col_q : col;
  assign mul_row  = (op == OP_FLUSH) ? min_row_q : row;
  assign span_col = {1'b0, max_col_q} - {1'b0, min_col_q} + 9'd1;
  assign span_row = {1'b0, max_row_q} - {1'b0, min_row_q} + 8'd1;

  always_comb begin
    wr_data_o            = '0;
    wr_data_o.op         = op;
    wr_data_o.x0         = 16'(cfg_i.cell_w) * 16'(mul_col);
    wr_data_o.y0         = 15'(15'(cfg_i.cell_h) * 15'(mul_row));
    wr_data_o.rect_w     = 16'(17'(cfg_i.cell_w) * 17'(span_col));
    wr_data_o.rect_h     = 15'(15'(cfg_i.cell_h) * 15'(span_row));
    wr_data_o.dirty      = any_q;
    wr_data_o.pix_x      = in_tdata_i[22:15];
    wr_data_o.pix_y      = in_tdata_i[30:23];
    wr_data_o.glyph_left = in_tdata_i[38:31];
    wr_data_o.glyph_top  = in_tdata_i[47:39];
    wr_data_o.coverage   = in_tdata_i[55:48];
    wr_data_o.bold       = in_tdata_i[56];
    wr_data_o.fg_color   = in_tdata_i[59:57];
    wr_data_o.bg_color   = in_tdata_i[62:60];
  end

endmodule

// File: rtl/tcgc_back.sv
// ----------------------------------------------------------------------------
// tcgc_back
// Pixel back end: placement, clipping and color blend in the first stage,
// frame buffer address in the second, which is also the output register.
// ----------------------------------------------------------------------------
module tcgc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcgc_pkg::cfg_t cfg_i,
  input  logic           rd_valid_i,
  output logic           rd_ready_o,
  input  tcgc_pkg::cmd_t rd_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           out_tuser_o,  // is_rect
  output logic [119:0]   out_tdata_o   // see top level for layout
);
  import tcgc_pkg::*;

  localparam logic [7:0] ChanBold = 8'hFF;
  localparam logic [7:0] ChanNorm = 8'hAF;
  localparam logic [8:0] BlendOne = 9'd256;

  function automatic logic [7:0] chan(input logic on, input logic bold);
    if (!on) return 8'd0;
    return bold ? ChanBold : ChanNorm;
  endfunction

  function automatic logic [7:0] blend(input logic [7:0] f, input logic [7:0] b,
                                       input logic [7:0] level);
    logic [16:0] sum;
    sum = 17'(f) * 17'(level) + 17'(b) * (17'(BlendOne) - 17'(level));
    return sum[15:8];
  endfunction

  function automatic logic [15:0] clip(input logic [15:0] start, input logic [15:0] len,
                                       input logic [12:0] limit);
    if (start >= 16'(limit)) return 16'd0;
    if (17'(start) + 17'(len) > 17'(limit)) return 16'(limit) - start;
    return len;
  endfunction

  cmd_t        c;
  logic [17:0] px, py, left_x, top_x;
  logic        px_ok, py_ok, in_cell, pix_valid;
  logic [23:0] rgb;

  logic        s1_v_q, s2_v_q, s1_en, s2_en;
  logic        s1_rect_q, s1_valid_q;
  logic [12:0] s1_px_q, s1_py_q;
  logic [23:0] s1_rgb_q;
  logic [15:0] s1_rx_q, s1_ry_q, s1_rw_q, s1_rh_q;
  logic [25:0] addr_full;

  logic         out_rect_q;
  logic [119:0] out_data_q;

  assign c      = rd_data_i;
  assign left_x = {{10{c.glyph_left[7]}}, c.glyph_left};
  assign top_x  = {{9{c.glyph_top[8]}}, c.glyph_top};

  // red (color bit 0) lands in the top byte, blue (bit 2) in the low byte
  always_comb begin
    px      = 18'(c.x0) + 18'(c.pix_x);
    py      = 18'(c.y0) + 18'(c.pix_y);
    in_cell = 1'b1;
    rgb     = '0;
    unique case (c.op)
      OP_GLYPH: begin
        px  = px + left_x;
        py  = py + 18'(cfg_i.ascender) - top_x;
        rgb = {blend(chan(c.fg_color[0], c.bold), chan(c.bg_color[0], c.bold), c.coverage),
               blend(chan(c.fg_color[1], c.bold), chan(c.bg_color[1], c.bold), c.coverage),
               blend(chan(c.fg_color[2], c.bold), chan(c.bg_color[2], c.bold), c.coverage)};
      end
      OP_FILL: begin
        in_cell = (c.pix_x < cfg_i.cell_w) && (c.pix_y < cfg_i.cell_h);
        rgb     = {chan(c.bg_color[0], c.bold), chan(c.bg_color[1], c.bold),
                   chan(c.bg_color[2], c.bold)};
      end
      default: begin
      end
    endcase
  end

  // negative coordinates show up as bit 17 set
  assign px_ok     = !px[17] && (px[16:0] < 17'(cfg_i.disp_w));
  assign py_ok     = !py[17] && (py[16:0] < 17'(cfg_i.disp_h));
  assign pix_valid = px_ok && py_ok && in_cell &&
                     ((c.op == OP_GLYPH) || (c.op == OP_FILL));

  assign s2_en      = !s2_v_q || out_ready_i;
  assign s1_en      = !s1_v_q || s2_en;
  assign rd_ready_o = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_en) s1_v_q <= rd_valid_i;
      if (s2_en) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_rect_q  <= (c.op == OP_FLUSH);
      s1_valid_q <= pix_valid;
      s1_px_q    <= px[12:0];
      s1_py_q    <= py[12:0];
      s1_rgb_q   <= rgb;
      if ((c.op == OP_FLUSH) && c.dirty) begin
        s1_rx_q <= c.x0;
        s1_ry_q <= 16'(c.y0);
        s1_rw_q <= clip(c.x0, c.rect_w, cfg_i.disp_w);
        s1_rh_q <= clip(16'(c.y0), 16'(c.rect_h), cfg_i.disp_h);
      end else begin
        s1_rx_q <= '0;
        s1_ry_q <= '0;
        s1_rw_q <= '0;
        s1_rh_q <= '0;
      end
    end
  end

  assign addr_full = 26'(s1_py_q) * 26'(cfg_i.disp_w) + 26'(s1_px_q);

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      out_rect_q <= s1_rect_q;
      out_data_q <= {7'd0, s1_rh_q, s1_rw_q, s1_ry_q, s1_rx_q,
                     s1_rgb_q,
                     s1_valid_q ? addr_full[23:0] : 24'd0,
                     s1_valid_q};
    end
  end

  assign out_valid_o = s2_v_q;
  assign out_tuser_o = out_rect_q;
  assign out_tdata_o = out_data_q;

  a_rect_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_tuser_o) |-> (out_tdata_o[48:0] == '0))
    else $error("flush result carries pixel fields");

  a_pixel_no_rect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_tuser_o) |-> (out_tdata_o[119:49] == '0))
    else $error("pixel result carries rectangle fields");

  a_invalid_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_tdata_o[0]) |-> (out_tdata_o[24:1] == '0))
    else $error("invalid pixel with nonzero address");

endmodule

// File: rtl/text_cell_glyph_compositor.sv
// ----------------------------------------------------------------------------
// text_cell_glyph_compositor
// Text terminal pixel compositor: glyph and fill pixels with dirty rectangle
// tracking, and flush of the rectangle clipped to the display.
// ----------------------------------------------------------------------------
// path: an accepted word goes through the queue, the first back end stage and the output register
// throughput: one word per clock while m_axis_tready holds; the queue and two back end
//   stages each take one word per cycle unless back-pressure from the output holds them
// reset: dirty rectangle cleared, registers at their defaults, queue and
//   pipeline empty; no clearing pass, words are taken right after reset
module text_cell_glyph_compositor #(
  parameter int MAX_COLS    = 256,
  parameter int MAX_ROWS    = 128,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // command stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [1:0]    s_axis_tuser,  // opcode
  // cell_col[7:0] cell_row[14:8] pix_x[22:15] pix_y[30:23] glyph_left[38:31]
  // glyph_top[47:39] coverage[55:48] bold[56] fg_color[59:57] bg_color[62:60]
  input  logic [63:0]   s_axis_tdata,
  // result stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic          m_axis_tuser,  // is_rect
  // pixel_valid[0] pixel_address[24:1] pixel_rgb[48:25] rect_x[64:49]
  // rect_y[80:65] rect_w[96:81] rect_h[112:97]
  output logic [119:0]  m_axis_tdata
);
  import tcgc_pkg::*;

  cfg_t cfg_q;
  logic cfg_wr;
  reg_e reg_idx;

  logic wr_valid, wr_ready, rd_valid, rd_ready;
  cmd_t wr_cmd, rd_cmd;

  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_w   <= 8'd16;
      cfg_q.cell_h   <= 8'd32;
      cfg_q.ascender <= 8'd24;
      cfg_q.disp_w   <= 13'd1920;
      cfg_q.disp_h   <= 13'd1080;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CELL_W:   cfg_q.cell_w   <= pwdata[7:0];
        REG_CELL_H:   cfg_q.cell_h   <= pwdata[7:0];
        REG_ASCENDER: cfg_q.ascender <= pwdata[7:0];
        REG_DISP_W:   cfg_q.disp_w   <= pwdata[12:0];
        REG_DISP_H:   cfg_q.disp_h   <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CELL_W:   prdata = 32'(cfg_q.cell_w);
      REG_CELL_H:   prdata = 32'(cfg_q.cell_h);
      REG_ASCENDER: prdata = 32'(cfg_q.ascender);
      REG_DISP_W:   prdata = 32'(cfg_q.disp_w);
      REG_DISP_H:   prdata = 32'(cfg_q.disp_h);
      default:      prdata = 32'd0;
    endcase
  end

  tcgc_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_tuser_i (s_axis_tuser),
    .in_tdata_i (s_axis_tdata),
    .wr_valid_o (wr_valid),
    .wr_ready_i (wr_ready),
    .wr_data_o  (wr_cmd)
  );

  tcgc_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_ready_o (wr_ready),
    .wr_data_i  (wr_cmd),
    .rd_valid_o (rd_valid),
    .rd_ready_i (rd_ready),
    .rd_data_o  (rd_cmd)
  );

  tcgc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rd_valid_i  (rd_valid),
    .rd_ready_o  (rd_ready),
    .rd_data_i   (rd_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tuser_o (m_axis_tuser),
    .out_tdata_o (m_axis_tdata)
  );

endmodule
